[design/skle_pkg.sv]
package skle_pkg;

  // Fixed field widths
  localparam int EST_W      = 48;
  localparam int VAR_W      = 32;
  localparam int TIME_W     = 32;
  localparam int DEN_W      = VAR_W + 1;
  localparam int GAIN_OUT_W = 17;
  localparam int SPLIT_W    = EST_W / 2;   // |innovation| goes through the multiplier in halves
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 48;
  localparam int S_DATA_W   = ((TIME_W + EST_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((EST_W + GAIN_OUT_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_DATA_W - EST_W - GAIN_OUT_W;

  // Reset values in whole units, scaled by the fraction width where used
  localparam int LIFE_RESET_INT = 180000;
  localparam int Q_RESET_INT    = 10;
  localparam int CENTI_DIV      = 100;

  localparam logic signed [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
  localparam logic signed [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_EST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Q_NOISE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R_NOISE  = 2'd3;

  // Microprogram
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT  = 4'd0;
  localparam step_t STEP_PRED  = 4'd1;
  localparam step_t STEP_DEN   = 4'd2;
  localparam step_t STEP_DLOAD = 4'd3;
  localparam step_t STEP_DIV   = 4'd4;
  localparam step_t STEP_GAIN  = 4'd5;
  localparam step_t STEP_MLO   = 4'd6;
  localparam step_t STEP_MHI   = 4'd7;
  localparam step_t STEP_ACC   = 4'd8;
  localparam step_t STEP_CORR  = 4'd9;
  localparam step_t STEP_MVAR  = 4'd10;
  localparam step_t STEP_VAR   = 4'd11;
  localparam step_t STEP_OUT   = 4'd12;

  typedef enum logic [3:0] {
    OP_NOP, OP_WAIT, OP_PRED, OP_DEN, OP_DLOAD, OP_DIV, OP_GAIN,
    OP_MLO, OP_MHI, OP_ACC, OP_CORR, OP_MVAR, OP_VAR, OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    JC_NEVER, JC_NO_INPUT, JC_DEN_ZERO, JC_DIV_MORE, JC_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    op_t    op;
    jcond_t jc;
    step_t  target;
    logic   last;
  } ctrl_t;

  typedef struct packed {
    logic no_input;
    logic den_zero;
    logic div_more;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '{op: OP_NOP, jc: JC_NEVER, target: STEP_WAIT, last: 1'b0};
    unique case (s)
      STEP_WAIT:  w = '{op: OP_WAIT,  jc: JC_NO_INPUT, target: STEP_WAIT, last: 1'b0};
      STEP_PRED:  w.op = OP_PRED;
      STEP_DEN:   w.op = OP_DEN;
      STEP_DLOAD: w = '{op: OP_DLOAD, jc: JC_DEN_ZERO, target: STEP_GAIN, last: 1'b0};
      STEP_DIV:   w = '{op: OP_DIV,   jc: JC_DIV_MORE, target: STEP_DIV,  last: 1'b0};
      STEP_GAIN:  w.op = OP_GAIN;
      STEP_MLO:   w.op = OP_MLO;
      STEP_MHI:   w.op = OP_MHI;
      STEP_ACC:   w.op = OP_ACC;
      STEP_CORR:  w.op = OP_CORR;
      STEP_MVAR:  w.op = OP_MVAR;
      STEP_VAR:   w.op = OP_VAR;
      STEP_OUT:   w = '{op: OP_OUT,   jc: JC_OUT_BUSY, target: STEP_OUT,  last: 1'b1};
      default:    w = '{op: OP_NOP,   jc: JC_NEVER,    target: STEP_WAIT, last: 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic signed [EST_W-1:0] sat_est(input logic signed [EST_W+1:0] v);
    logic [2:0] hi3;
    hi3 = v[EST_W+1:EST_W-1];
    if (hi3 == 3'b000 || hi3 == 3'b111) begin
      return v[EST_W-1:0];
    end else if (v[EST_W+1]) begin
      return EST_MIN;
    end else begin
      return EST_MAX;
    end
  endfunction

endpackage

[design/skle_seq.sv]
module skle_seq
  import skle_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t cw
);

  step_t step;
  step_t step_next;
  logic  take;

  assign cw = ucode(step);

  always_comb begin
    unique case (cw.jc)
      JC_NEVER:    take = 1'b0;
      JC_NO_INPUT: take = stat.no_input;
      JC_DEN_ZERO: take = stat.den_zero;
      JC_DIV_MORE: take = stat.div_more;
      JC_OUT_BUSY: take = stat.out_busy;
      default:     take = 1'b0;
    endcase
    if (take) begin
      step_next = cw.target;
    end else if (cw.last) begin
      step_next = STEP_WAIT;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_WAIT && !stat.no_input) |=> (step == STEP_PRED))
    else $error("accepted word did not start the prediction step");

endmodule

[design/skle_div.sv]
module skle_div
  import skle_pkg::*;
#(
  parameter int QW = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  iter,
  input  logic [VAR_W+QW-1:0]   num,
  input  logic [DEN_W-1:0]      den,
  output logic [QW-1:0]         quo,
  output logic                  more
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [DEN_W:0]   rem;
  logic [QW-1:0]    q;
  logic [DEN_W-1:0] dv;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             ge;

  // Quotient fits QW bits, so the upper numerator bits start out below the divisor
  always_comb begin
    trial = {rem[DEN_W-1:0], q[QW-1]};
    ge    = (trial >= {1'b0, dv});
  end

  assign quo  = q;
  assign more = (cnt > CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= CNT_W'(QW);
    end else if (iter && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= (DEN_W+1)'(num[VAR_W+QW-1:QW]);
      q   <= num[QW-1:0];
      dv  <= den;
    end else if (iter) begin
      rem <= ge ? (trial - {1'b0, dv}) : trial;
      q   <= {q[QW-2:0], ge};
    end
  end

  // A zero divisor is loaded but never iterated, so only a live divide is checked
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0 && dv != '0) |-> (rem < {1'b0, dv}))
    else $error("partial remainder reached the divisor");

endmodule

[design/skle_dp.sv]
module skle_dp
  import skle_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_t                cw,
  output stat_t                stat,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata
);

  localparam int F      = FRACTION_BITS;
  localparam int QW     = F + 1;
  localparam int NUM_W  = VAR_W + QW;
  localparam int MP_W   = VAR_W + QW;
  localparam int ACC_W  = EST_W + QW;
  localparam int WIDE_W = EST_W + 2;

  localparam logic [QW-1:0]    ONE_K    = {1'b1, {F{1'b0}}};
  localparam logic [MP_W-1:0]  HALF_P   = MP_W'(1) << (F - 1);
  localparam logic [ACC_W-1:0] HALF_A   = ACC_W'(1) << (F - 1);
  localparam logic [EST_W-1:0] RST_EST  = EST_W'(64'(LIFE_RESET_INT) << F);
  localparam logic [VAR_W-1:0] RST_CENT = VAR_W'(((64'd1 << F) + 64'(CENTI_DIV / 2))
                                                 / 64'(CENTI_DIV));
  localparam logic [VAR_W-1:0] RST_Q    = VAR_W'(64'(Q_RESET_INT) << F);

  // Configuration and filter state
  logic signed [EST_W-1:0] init_est;
  logic [VAR_W-1:0]        init_cov;
  logic [VAR_W-1:0]        q_noise;
  logic [VAR_W-1:0]        r_noise;
  logic signed [EST_W-1:0] estimate;
  logic [VAR_W-1:0]        variance;

  // Working registers
  logic [TIME_W-1:0]       dt;
  logic signed [EST_W-1:0] z;
  logic signed [EST_W-1:0] xp;
  logic [VAR_W-1:0]        pp;
  logic [DEN_W-1:0]        den;
  logic [QW-1:0]           k;
  logic                    neg;
  logic [EST_W-1:0]        mag;
  logic [MP_W-1:0]         prod;
  logic [ACC_W-1:0]        acc;
  logic signed [EST_W-1:0] est_new;
  logic [VAR_W-1:0]        var_new;
  logic [EST_W-1:0]        out_est;
  logic [GAIN_OUT_W-1:0]   out_gain;

  logic                     accept;
  logic                     out_load;
  logic signed [WIDE_W-1:0] xp_wide;
  logic [VAR_W:0]           pp_sum;
  logic [VAR_W-1:0]         pp_calc;
  logic [DEN_W-1:0]         den_calc;
  logic [NUM_W-1:0]         num;
  logic [QW-1:0]            quo;
  logic                     div_more;
  logic signed [WIDE_W-1:0] e_wide;
  logic signed [WIDE_W-1:0] mag_wide;
  logic [QW-1:0]            k_calc;
  logic [VAR_W-1:0]         mul_a;
  logic [QW-1:0]            mul_b;
  logic [MP_W-1:0]          mul_p;
  logic [ACC_W-1:0]         acc_sum;
  logic [ACC_W-1:0]         corr_wide;
  logic [EST_W:0]           corr;
  logic signed [WIDE_W-1:0] est_wide;
  logic [MP_W-1:0]          var_wide;
  logic [VAR_W-1:0]         var_calc;

  assign s_tready = (cw.op == OP_WAIT);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (cw.op == OP_OUT) && !stat.out_busy;
  assign m_tdata  = {{M_PAD_W{1'b0}}, out_gain, out_est};

  assign stat.no_input = !s_tvalid;
  assign stat.den_zero = (den == '0);
  assign stat.div_more = div_more;
  assign stat.out_busy = m_tvalid && !m_tready;

  always_comb begin
    // prediction
    xp_wide  = WIDE_W'(estimate) - $signed(WIDE_W'(dt));
    pp_sum   = {1'b0, variance} + {1'b0, q_noise};
    pp_calc  = pp_sum[VAR_W] ? '1 : pp_sum[VAR_W-1:0];
    den_calc = {1'b0, pp} + {1'b0, r_noise};
    // round half up: add half the divisor to the scaled numerator
    num      = (NUM_W'(pp) << F) + NUM_W'(den >> 1);
    // innovation magnitude and sign
    e_wide   = WIDE_W'(z) - WIDE_W'(xp);
    mag_wide = e_wide[WIDE_W-1] ? -e_wide : e_wide;
    if (den == '0) begin
      k_calc = '0;
    end else if (quo > ONE_K) begin
      k_calc = ONE_K;
    end else begin
      k_calc = quo;
    end
    // shared multiplier
    unique case (cw.op)
      OP_MLO: begin
        mul_a = VAR_W'(mag[SPLIT_W-1:0]);
        mul_b = k;
      end
      OP_MHI: begin
        mul_a = VAR_W'(mag[EST_W-1:SPLIT_W]);
        mul_b = k;
      end
      default: begin
        mul_a = pp;
        mul_b = ONE_K - k;
      end
    endcase
    mul_p     = MP_W'({{QW{1'b0}}, mul_a} * {{VAR_W{1'b0}}, mul_b});
    acc_sum   = acc + (ACC_W'(prod) << SPLIT_W);
    // correction rounds half away from zero by working on the magnitude
    corr_wide = (acc + HALF_A) >> F;
    corr      = corr_wide[EST_W:0];
    est_wide  = neg ? (WIDE_W'(xp) - $signed(WIDE_W'(corr)))
                    : (WIDE_W'(xp) + $signed(WIDE_W'(corr)));
    var_wide  = (prod + HALF_P) >> F;
    var_calc  = (|var_wide[MP_W-1:VAR_W]) ? '1 : var_wide[VAR_W-1:0];
  end

  skle_div #(
    .QW(QW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .load (cw.op == OP_DLOAD),
    .iter (cw.op == OP_DIV),
    .num  (num),
    .den  (den),
    .quo  (quo),
    .more (div_more)
  );

  // Control, configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      init_est <= RST_EST;
      init_cov <= RST_CENT;
      q_noise  <= RST_Q;
      r_noise  <= RST_CENT;
      estimate <= RST_EST;
      variance <= RST_CENT;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_INIT_EST: init_est <= cfg_data;
          REG_INIT_COV: init_cov <= cfg_data[VAR_W-1:0];
          REG_Q_NOISE:  q_noise  <= cfg_data[VAR_W-1:0];
          REG_R_NOISE:  r_noise  <= cfg_data[VAR_W-1:0];
        endcase
        // any write reloads the filter from the starting values
        estimate <= (cfg_index == REG_INIT_EST) ? cfg_data : init_est;
        variance <= (cfg_index == REG_INIT_COV) ? cfg_data[VAR_W-1:0] : init_cov;
      end else if (out_load) begin
        estimate <= est_new;
        variance <= var_new;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Working registers, stepped by the control word
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_WAIT: begin
        if (accept) begin
          dt <= s_tdata[TIME_W-1:0];
          z  <= s_tdata[TIME_W+EST_W-1:TIME_W];
        end
      end
      OP_PRED: begin
        xp <= sat_est(xp_wide);
        pp <= pp_calc;
      end
      OP_DEN: den <= den_calc;
      OP_GAIN: begin
        k   <= k_calc;
        neg <= e_wide[WIDE_W-1];
        mag <= mag_wide[EST_W-1:0];
      end
      OP_MLO: prod <= mul_p;
      OP_MHI: begin
        acc  <= ACC_W'(prod);
        prod <= mul_p;
      end
      OP_ACC:  acc <= acc_sum;
      OP_CORR: est_new <= sat_est(est_wide);
      OP_MVAR: prod <= mul_p;
      OP_VAR:  var_new <= var_calc;
      OP_OUT: begin
        if (out_load) begin
          out_est  <= est_new;
          out_gain <= GAIN_OUT_W'(k);
        end
      end
      default: begin
      end
    endcase
  end

  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_MLO) |-> (k <= ONE_K))
    else $error("gain above one");

  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tvalid && m_tdata[EST_W-1:0] == $past(est_new)))
    else $error("result word not loaded at the output step");

endmodule

[design/scalar_kalman_life_estimator.sv]
// An accepted input word passes through the prediction, gain denominator, divider, gain,
// multiply, correction, variance and output steps in order; the divider steps are skipped
// when the gain denominator is zero. A new word is accepted only after the previous one has
// left the output step. The restoring gain divider retires one quotient bit per step.
// A finished word waits in the output register; the output step holds while it is unaccepted.
// Reset (rst, synchronous): control, configuration and filter registers take their defaults.
module scalar_kalman_life_estimator
  import skle_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_DATA_W-1:0]  s_tdata,   // elapsed_time[31:0], measured_life[79:32]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_DATA_W-1:0]  m_tdata    // corrected_estimate[47:0], gain_used[64:48], zeros
);

  ctrl_t cw;
  stat_t stat;

  skle_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw)
  );

  skle_dp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cw        (cw),
    .stat      (stat),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
